/* rtl/core/zbr_pkg.sv */
package zbr_pkg;

    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 240;
    localparam int DEF_DEPTH_BITS    = 16;

    // Fixed field widths of the stream.
    localparam int CRD_W = 16;
    localparam int ZIN_W = 16;
    localparam int COL_W = 24;
    localparam int OP_W  = 2;

    // Internal arithmetic widths.
    localparam int EDGE_W  = CRD_W + 1;
    localparam int DELTA_W = CRD_W + 2;
    localparam int APROD_W = 2 * EDGE_W;
    localparam int AREA_W  = APROD_W + 1;
    localparam int EPROD_W = DELTA_W + EDGE_W;
    localparam int NUM_W   = EPROD_W + 1;
    localparam int N0_W    = NUM_W + 2;
    localparam int WGT_W   = AREA_W;
    localparam int WPROD_W = WGT_W + ZIN_W;
    localparam int SUM_W   = WPROD_W + 2;
    localparam int QUO_W   = ZIN_W;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_PIXEL = 2'd2;

    localparam logic [7:0] ALPHA = 8'hFF;

    typedef struct packed {
        logic valid;
        logic done;
        logic hit;
    } zbr_tag_t;

endpackage

/* rtl/core/zbr_ram.sv */
module zbr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/zbr_setup.sv */
module zbr_setup #(
    parameter int SCREEN_WIDTH  = zbr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = zbr_pkg::DEF_SCREEN_HEIGHT,
    parameter int XW            = $clog2(SCREEN_WIDTH),
    parameter int YW            = $clog2(SCREEN_HEIGHT)
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       adv,
    input  logic                                       in_beat,
    input  logic [zbr_pkg::OP_W-1:0]                   opcode,
    input  logic [5:0][zbr_pkg::CRD_W-1:0]             crd_in,
    input  logic [2:0][zbr_pkg::ZIN_W-1:0]             dz_in,
    input  logic [zbr_pkg::COL_W-1:0]                  colour_in,
    output zbr_pkg::zbr_tag_t                          tag_o,
    output logic [XW-1:0]                              x_o,
    output logic [YW-1:0]                              y_o,
    output logic signed [zbr_pkg::DELTA_W-1:0]         dx_o,
    output logic signed [zbr_pkg::DELTA_W-1:0]         dy_o,
    output logic signed [zbr_pkg::EDGE_W-1:0]          e0x_o,
    output logic signed [zbr_pkg::EDGE_W-1:0]          e0y_o,
    output logic signed [zbr_pkg::EDGE_W-1:0]          e1x_o,
    output logic signed [zbr_pkg::EDGE_W-1:0]          e1y_o,
    output logic [zbr_pkg::AREA_W-1:0]                 area_o,
    output logic [2:0][zbr_pkg::ZIN_W-1:0]             dz_o,
    output logic [zbr_pkg::COL_W-1:0]                  colour_o,
    output logic                                       busy_o
);

    localparam int CW = zbr_pkg::CRD_W;
    localparam int EW = zbr_pkg::EDGE_W;
    localparam int DW = zbr_pkg::DELTA_W;
    localparam int ZW = zbr_pkg::ZIN_W;

    // Scan position.
    logic [XW-1:0] col_reg;
    logic [YW-1:0] row_reg;
    logic          loaded_reg;
    logic          pix_go;
    logic          ld_go;
    logic          last_pix;
    logic          row_end;

    assign pix_go   = in_beat && (opcode == zbr_pkg::OP_PIXEL) && loaded_reg;
    assign ld_go    = in_beat && (opcode == zbr_pkg::OP_LOAD);
    assign row_end  = (col_reg == XW'(SCREEN_WIDTH - 1));
    assign last_pix = row_end && (row_reg == YW'(SCREEN_HEIGHT - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            loaded_reg <= 1'b0;
        end else if (ld_go) begin
            col_reg    <= '0;
            row_reg    <= '0;
            loaded_reg <= 1'b1;
        end else if (pix_go) begin
            if (last_pix) begin
                loaded_reg <= 1'b0;
            end else if (row_end) begin
                col_reg <= '0;
                row_reg <= row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Sort by y with three compare-exchange steps.
    logic signed [CW-1:0] sort_c [6];
    logic [2:0][ZW-1:0]   sort_z;

    always_comb begin
        logic signed [CW-1:0] tx;
        logic signed [CW-1:0] ty;
        logic [ZW-1:0]        tz;
        tx = '0;
        ty = '0;
        tz = '0;
        for (int i = 0; i < 6; i++) begin
            sort_c[i] = $signed(crd_in[i]);
        end
        sort_z = dz_in;
        if (sort_c[1] > sort_c[3]) begin
            tx = sort_c[0]; ty = sort_c[1]; tz = sort_z[0];
            sort_c[0] = sort_c[2]; sort_c[1] = sort_c[3]; sort_z[0] = sort_z[1];
            sort_c[2] = tx; sort_c[3] = ty; sort_z[1] = tz;
        end
        if (sort_c[1] > sort_c[5]) begin
            tx = sort_c[0]; ty = sort_c[1]; tz = sort_z[0];
            sort_c[0] = sort_c[4]; sort_c[1] = sort_c[5]; sort_z[0] = sort_z[2];
            sort_c[4] = tx; sort_c[5] = ty; sort_z[2] = tz;
        end
        if (sort_c[3] > sort_c[5]) begin
            tx = sort_c[2]; ty = sort_c[3]; tz = sort_z[1];
            sort_c[2] = sort_c[4]; sort_c[3] = sort_c[5]; sort_z[1] = sort_z[2];
            sort_c[4] = tx; sort_c[5] = ty; sort_z[2] = tz;
        end
    end

    // Stage 1: sorted vertices.
    logic                 ld1_reg;
    zbr_pkg::zbr_tag_t    tag1_reg;
    logic [XW-1:0]        x1_reg;
    logic [YW-1:0]        y1_reg;
    logic signed [CW-1:0] crd1_reg [6];
    logic [2:0][ZW-1:0]   dz1_reg;
    logic [zbr_pkg::COL_W-1:0] col1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ld1_reg  <= 1'b0;
            tag1_reg <= '0;
        end else if (adv) begin
            ld1_reg  <= ld_go;
            tag1_reg <= '{valid: pix_go, done: last_pix, hit: 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg   <= col_reg;
            y1_reg   <= row_reg;
            crd1_reg <= sort_c;
            dz1_reg  <= sort_z;
            col1_reg <= colour_in;
        end
    end

    // Stage 2: the two cross products of the area.
    logic signed [EW-1:0] ae0x;
    logic signed [EW-1:0] ae0y;
    logic signed [EW-1:0] ae1x;
    logic signed [EW-1:0] ae1y;

    assign ae0x = EW'(crd1_reg[2]) - EW'(crd1_reg[0]);
    assign ae0y = EW'(crd1_reg[3]) - EW'(crd1_reg[1]);
    assign ae1x = EW'(crd1_reg[4]) - EW'(crd1_reg[0]);
    assign ae1y = EW'(crd1_reg[5]) - EW'(crd1_reg[1]);

    logic                 ld2_reg;
    zbr_pkg::zbr_tag_t    tag2_reg;
    logic [XW-1:0]        x2_reg;
    logic [YW-1:0]        y2_reg;
    logic signed [CW-1:0] crd2_reg [6];
    logic [2:0][ZW-1:0]   dz2_reg;
    logic [zbr_pkg::COL_W-1:0] col2_reg;
    logic signed [zbr_pkg::APROD_W-1:0] pa2_reg;
    logic signed [zbr_pkg::APROD_W-1:0] pb2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ld2_reg  <= 1'b0;
            tag2_reg <= '0;
        end else if (adv) begin
            ld2_reg  <= ld1_reg;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            crd2_reg <= crd1_reg;
            dz2_reg  <= dz1_reg;
            col2_reg <= col1_reg;
            pa2_reg  <= ae0x * ae1y;
            pb2_reg  <= ae0y * ae1x;
        end
    end

    // Negative winding: swap the first and last vertex, which negates the area.
    logic signed [zbr_pkg::AREA_W-1:0] area2;
    logic signed [CW-1:0]              fix_c [6];
    logic [2:0][ZW-1:0]                fix_z;
    logic [zbr_pkg::AREA_W-1:0]        area_mag;

    assign area2 = zbr_pkg::AREA_W'(pa2_reg) - zbr_pkg::AREA_W'(pb2_reg);

    always_comb begin
        fix_c    = crd2_reg;
        fix_z    = dz2_reg;
        area_mag = area2;
        if (area2 < 0) begin
            fix_c[0] = crd2_reg[4];
            fix_c[1] = crd2_reg[5];
            fix_c[4] = crd2_reg[0];
            fix_c[5] = crd2_reg[1];
            fix_z[0] = dz2_reg[2];
            fix_z[2] = dz2_reg[0];
            area_mag = -area2;
        end
    end

    // Current triangle.
    logic signed [CW-1:0]         tc_reg [6];
    logic [2:0][ZW-1:0]           tz_reg;
    logic [zbr_pkg::COL_W-1:0]    tcol_reg;
    logic [zbr_pkg::AREA_W-1:0]   ta_reg;

    always_ff @(posedge aclk) begin
        if (adv && ld2_reg) begin
            tc_reg   <= fix_c;
            tz_reg   <= fix_z;
            tcol_reg <= col2_reg;
            ta_reg   <= area_mag;
        end
    end

    // Stage 3: pixel offsets and edge vectors.
    zbr_pkg::zbr_tag_t tag3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag3_reg <= '0;
        end else if (adv) begin
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_o      <= x2_reg;
            y_o      <= y2_reg;
            dx_o     <= $signed(DW'({x2_reg, 4'b0000})) - DW'(tc_reg[0]);
            dy_o     <= $signed(DW'({y2_reg, 4'b0000})) - DW'(tc_reg[1]);
            e0x_o    <= EW'(tc_reg[2]) - EW'(tc_reg[0]);
            e0y_o    <= EW'(tc_reg[3]) - EW'(tc_reg[1]);
            e1x_o    <= EW'(tc_reg[4]) - EW'(tc_reg[0]);
            e1y_o    <= EW'(tc_reg[5]) - EW'(tc_reg[1]);
            area_o   <= ta_reg;
            dz_o     <= tz_reg;
            colour_o <= tcol_reg;
        end
    end

    assign tag_o  = tag3_reg;
    assign busy_o = tag1_reg.valid || tag2_reg.valid || tag3_reg.valid;

endmodule

/* rtl/core/zbr_edge.sv */
module zbr_edge #(
    parameter int SCREEN_WIDTH = zbr_pkg::DEF_SCREEN_WIDTH,
    parameter int XW           = 9,
    parameter int YW           = 8,
    parameter int ADDR_W       = 17
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 adv,
    input  zbr_pkg::zbr_tag_t                    tag_i,
    input  logic [XW-1:0]                        x_i,
    input  logic [YW-1:0]                        y_i,
    input  logic signed [zbr_pkg::DELTA_W-1:0]   dx_i,
    input  logic signed [zbr_pkg::DELTA_W-1:0]   dy_i,
    input  logic signed [zbr_pkg::EDGE_W-1:0]    e0x_i,
    input  logic signed [zbr_pkg::EDGE_W-1:0]    e0y_i,
    input  logic signed [zbr_pkg::EDGE_W-1:0]    e1x_i,
    input  logic signed [zbr_pkg::EDGE_W-1:0]    e1y_i,
    input  logic [zbr_pkg::AREA_W-1:0]           area_i,
    input  logic [2:0][zbr_pkg::ZIN_W-1:0]       dz_i,
    input  logic [zbr_pkg::COL_W-1:0]            colour_i,
    output zbr_pkg::zbr_tag_t                    tag_o,
    output logic [XW-1:0]                        x_o,
    output logic [YW-1:0]                        y_o,
    output logic [ADDR_W-1:0]                    addr_o,
    output logic [zbr_pkg::AREA_W-1:0]           area_o,
    output logic [zbr_pkg::COL_W-1:0]            colour_o,
    output logic [zbr_pkg::SUM_W-1:0]            sum_o,
    output logic                                 busy_o
);

    localparam int AW  = zbr_pkg::AREA_W;
    localparam int PW  = zbr_pkg::EPROD_W;
    localparam int NW  = zbr_pkg::NUM_W;
    localparam int N0W = zbr_pkg::N0_W;
    localparam int WW  = zbr_pkg::WGT_W;
    localparam int WPW = zbr_pkg::WPROD_W;
    localparam int SW  = zbr_pkg::SUM_W;
    localparam int ZW  = zbr_pkg::ZIN_W;
    localparam int CLW = zbr_pkg::COL_W;

    zbr_pkg::zbr_tag_t tag4_reg;
    zbr_pkg::zbr_tag_t tag5_reg;
    zbr_pkg::zbr_tag_t tag6_reg;
    zbr_pkg::zbr_tag_t tag7_reg;
    zbr_pkg::zbr_tag_t tag8_reg;

    logic [XW-1:0]      x4_reg, x5_reg, x6_reg, x7_reg;
    logic [YW-1:0]      y4_reg, y5_reg, y6_reg, y7_reg;
    logic [ADDR_W-1:0]  addr4_reg, addr5_reg, addr6_reg, addr7_reg;
    logic [AW-1:0]      a4_reg, a5_reg, a6_reg, a7_reg;
    logic [CLW-1:0]     col4_reg, col5_reg, col6_reg, col7_reg;
    logic [2:0][ZW-1:0] dz4_reg, dz5_reg, dz6_reg;

    logic signed [PW-1:0] ma4_reg, mb4_reg, mc4_reg, md4_reg;
    logic signed [NW-1:0] n1_5_reg, n2_5_reg;
    logic [WW-1:0]        w0_6_reg, w1_6_reg, w2_6_reg;
    logic [WPW-1:0]       p0_7_reg, p1_7_reg, p2_7_reg;

    logic signed [N0W-1:0] n0_5;
    logic                  inside5;

    assign n0_5 = $signed({3'b000, a5_reg}) - N0W'(n1_5_reg) - N0W'(n2_5_reg);
    assign inside5 = (a5_reg != '0) && !n1_5_reg[NW-1] && !n2_5_reg[NW-1] && !n0_5[N0W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag4_reg <= '0;
            tag5_reg <= '0;
            tag6_reg <= '0;
            tag7_reg <= '0;
            tag8_reg <= '0;
        end else if (adv) begin
            tag4_reg <= tag_i;
            tag5_reg <= tag4_reg;
            tag6_reg <= '{valid: tag5_reg.valid, done: tag5_reg.done, hit: inside5};
            tag7_reg <= tag6_reg;
            tag8_reg <= tag7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // Edge products.
            ma4_reg   <= dx_i * e1y_i;
            mb4_reg   <= dy_i * e1x_i;
            mc4_reg   <= e0x_i * dy_i;
            md4_reg   <= e0y_i * dx_i;
            x4_reg    <= x_i;
            y4_reg    <= y_i;
            addr4_reg <= ADDR_W'(y_i) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(x_i);
            a4_reg    <= area_i;
            col4_reg  <= colour_i;
            dz4_reg   <= dz_i;

            // Edge functions.
            n1_5_reg  <= NW'(ma4_reg) - NW'(mb4_reg);
            n2_5_reg  <= NW'(mc4_reg) - NW'(md4_reg);
            x5_reg    <= x4_reg;
            y5_reg    <= y4_reg;
            addr5_reg <= addr4_reg;
            a5_reg    <= a4_reg;
            col5_reg  <= col4_reg;
            dz5_reg   <= dz4_reg;

            // Weights; meaningful only when the pixel is inside.
            w0_6_reg  <= WW'(n0_5);
            w1_6_reg  <= WW'(n1_5_reg);
            w2_6_reg  <= WW'(n2_5_reg);
            x6_reg    <= x5_reg;
            y6_reg    <= y5_reg;
            addr6_reg <= addr5_reg;
            a6_reg    <= a5_reg;
            col6_reg  <= col5_reg;
            dz6_reg   <= dz5_reg;

            // Weighted depths.
            p0_7_reg  <= w0_6_reg * dz6_reg[0];
            p1_7_reg  <= w1_6_reg * dz6_reg[1];
            p2_7_reg  <= w2_6_reg * dz6_reg[2];
            x7_reg    <= x6_reg;
            y7_reg    <= y6_reg;
            addr7_reg <= addr6_reg;
            a7_reg    <= a6_reg;
            col7_reg  <= col6_reg;

            sum_o     <= SW'(p0_7_reg) + SW'(p1_7_reg) + SW'(p2_7_reg);
            x_o       <= x7_reg;
            y_o       <= y7_reg;
            addr_o    <= addr7_reg;
            area_o    <= a7_reg;
            colour_o  <= col7_reg;
        end
    end

    assign tag_o  = tag8_reg;
    assign busy_o = tag4_reg.valid || tag5_reg.valid || tag6_reg.valid
                 || tag7_reg.valid || tag8_reg.valid;

endmodule

/* rtl/core/zbr_div.sv */
module zbr_div #(
    parameter int SIDE_W = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             adv,
    input  logic                             in_valid,
    input  logic [zbr_pkg::SUM_W-1:0]        num_i,
    input  logic [zbr_pkg::AREA_W-1:0]       den_i,
    input  logic [SIDE_W-1:0]                side_i,
    output logic                             out_valid,
    output logic [zbr_pkg::QUO_W-1:0]        quo_o,
    output logic [SIDE_W-1:0]                side_o,
    output logic                             busy_o
);

    localparam int QW = zbr_pkg::QUO_W;
    localparam int SW = zbr_pkg::SUM_W;
    localparam int AW = zbr_pkg::AREA_W;

    // One quotient bit per stage, most significant first. The quotient is a
    // weighted mean of 16-bit depths for a pixel inside the triangle, so it fits QW bits.
    logic [QW-1:0]     v_reg;
    logic [SW-1:0]     rem_reg  [QW];
    logic [QW-1:0]     q_reg    [QW];
    logic [AW-1:0]     den_reg  [QW];
    logic [SIDE_W-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic              v_in;
        logic [SW-1:0]     rem_in;
        logic [QW-1:0]     q_in;
        logic [AW-1:0]     den_in;
        logic [SIDE_W-1:0] side_in;
        logic [SW-1:0]     trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = num_i;
            assign q_in    = '0;
            assign den_in  = den_i;
            assign side_in = side_i;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = SW'(den_in) << (QW - 1 - k);
        assign ge    = (rem_in >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (adv) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k]  <= ge ? (rem_in - trial) : rem_in;
                q_reg[k]    <= q_in | (QW'(ge) << (QW - 1 - k));
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo_o     = q_reg[QW-1];
    assign side_o    = side_reg[QW-1];
    assign busy_o    = |v_reg;

endmodule

/* rtl/core/zbuffer_triangle_rasterizer.sv */
// Depth-buffered triangle filler. A beat with opcode 1 loads a triangle, and
// each following opcode 2 beat tests the next pixel in raster order and
// returns one result beat for it; m_tlast marks the last pixel of the screen,
// after which pixel beats are dropped until the next load. Pixel beats are
// taken one per clock while the output is not stalled and no clear is pending
// or running; each result passes through the setup stages, edge and depth
// stages, divider stages, the depth memory read and the output register.
// The depth memory holds SCREEN_WIDTH*SCREEN_HEIGHT words of DEPTH_BITS;
// opcode 0 and reset clear it with a sweep that writes one word per clock, so
// s_tready stays low while the beats still in flight drain and the sweep
// covers every word. Opcode 3 is ignored.
module zbuffer_triangle_rasterizer #(
    parameter int SCREEN_WIDTH  = zbr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = zbr_pkg::DEF_SCREEN_HEIGHT,
    parameter int DEPTH_BITS    = zbr_pkg::DEF_DEPTH_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
    // vertex_a_depth, vertex_b_depth, vertex_c_depth, fill_colour
    input  logic [167:0] s_tdata,
    // opcode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pixel_x, pixel_y, pixel_word, zero fill
    output logic [55:0]  m_tdata,
    // pixel_written
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    localparam int XW       = $clog2(SCREEN_WIDTH);
    localparam int YW       = $clog2(SCREEN_HEIGHT);
    localparam int PIXELS   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W   = $clog2(PIXELS);
    localparam int CLW      = zbr_pkg::COL_W;
    localparam int QW       = zbr_pkg::QUO_W;
    localparam int SIDE_W   = 2 + XW + YW + ADDR_W + CLW;

    logic adv;
    logic s_beat;

    assign adv    = !m_tvalid || m_tready;
    assign s_beat = s_tvalid && s_tready;

    // Front end: sorting, area and scan position.
    zbr_pkg::zbr_tag_t                      st_tag;
    logic [XW-1:0]                          st_x;
    logic [YW-1:0]                          st_y;
    logic signed [zbr_pkg::DELTA_W-1:0]     st_dx, st_dy;
    logic signed [zbr_pkg::EDGE_W-1:0]      st_e0x, st_e0y, st_e1x, st_e1y;
    logic [zbr_pkg::AREA_W-1:0]             st_area;
    logic [2:0][zbr_pkg::ZIN_W-1:0]         st_dz;
    logic [CLW-1:0]                         st_col;
    logic                                   st_busy;
    logic [5:0][zbr_pkg::CRD_W-1:0]         crd_in;
    logic [2:0][zbr_pkg::ZIN_W-1:0]         dz_in;

    assign crd_in = s_tdata[95:0];
    assign dz_in  = s_tdata[143:96];

    zbr_setup #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .XW           (XW),
        .YW           (YW)
    ) u_setup (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_beat  (s_beat),
        .opcode   (s_tuser),
        .crd_in   (crd_in),
        .dz_in    (dz_in),
        .colour_in(s_tdata[167:144]),
        .tag_o    (st_tag),
        .x_o      (st_x),
        .y_o      (st_y),
        .dx_o     (st_dx),
        .dy_o     (st_dy),
        .e0x_o    (st_e0x),
        .e0y_o    (st_e0y),
        .e1x_o    (st_e1x),
        .e1y_o    (st_e1y),
        .area_o   (st_area),
        .dz_o     (st_dz),
        .colour_o (st_col),
        .busy_o   (st_busy)
    );

    zbr_pkg::zbr_tag_t           ed_tag;
    logic [XW-1:0]               ed_x;
    logic [YW-1:0]               ed_y;
    logic [ADDR_W-1:0]           ed_addr;
    logic [zbr_pkg::AREA_W-1:0]  ed_area;
    logic [CLW-1:0]              ed_col;
    logic [zbr_pkg::SUM_W-1:0]   ed_sum;
    logic                        ed_busy;

    zbr_edge #(
        .SCREEN_WIDTH(SCREEN_WIDTH),
        .XW          (XW),
        .YW          (YW),
        .ADDR_W      (ADDR_W)
    ) u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .tag_i   (st_tag),
        .x_i     (st_x),
        .y_i     (st_y),
        .dx_i    (st_dx),
        .dy_i    (st_dy),
        .e0x_i   (st_e0x),
        .e0y_i   (st_e0y),
        .e1x_i   (st_e1x),
        .e1y_i   (st_e1y),
        .area_i  (st_area),
        .dz_i    (st_dz),
        .colour_i(st_col),
        .tag_o   (ed_tag),
        .x_o     (ed_x),
        .y_o     (ed_y),
        .addr_o  (ed_addr),
        .area_o  (ed_area),
        .colour_o(ed_col),
        .sum_o   (ed_sum),
        .busy_o  (ed_busy)
    );

    logic              dv_valid;
    logic [QW-1:0]     dv_quo;
    logic [SIDE_W-1:0] dv_side;
    logic              dv_busy;
    logic              dv_done;
    logic              dv_inside;
    logic [XW-1:0]     dv_x;
    logic [YW-1:0]     dv_y;
    logic [ADDR_W-1:0] dv_addr;
    logic [CLW-1:0]    dv_col;

    zbr_div #(
        .SIDE_W(SIDE_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (ed_tag.valid),
        .num_i    (ed_sum),
        .den_i    (ed_area),
        .side_i   ({ed_tag.done, ed_tag.hit, ed_x, ed_y, ed_addr, ed_col}),
        .out_valid(dv_valid),
        .quo_o    (dv_quo),
        .side_o   (dv_side),
        .busy_o   (dv_busy)
    );

    assign {dv_done, dv_inside, dv_x, dv_y, dv_addr, dv_col} = dv_side;

    // Scale the 16-bit depth to the store width.
    logic [DEPTH_BITS-1:0] dv_z;

    if (DEPTH_BITS >= QW) begin : g_widen
        assign dv_z = DEPTH_BITS'(dv_quo) << (DEPTH_BITS - QW);
    end else begin : g_narrow
        assign dv_z = DEPTH_BITS'(dv_quo >> (QW - DEPTH_BITS));
    end

    // Depth test stage.
    logic                  m2_valid_reg;
    logic                  m2_done_reg;
    logic                  m2_inside_reg;
    logic [XW-1:0]         m2_x_reg;
    logic [YW-1:0]         m2_y_reg;
    logic [ADDR_W-1:0]     m2_addr_reg;
    logic [CLW-1:0]        m2_col_reg;
    logic [DEPTH_BITS-1:0] m2_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_valid_reg <= 1'b0;
        end else if (adv) begin
            m2_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m2_done_reg   <= dv_done;
            m2_inside_reg <= dv_inside;
            m2_x_reg      <= dv_x;
            m2_y_reg      <= dv_y;
            m2_addr_reg   <= dv_addr;
            m2_col_reg    <= dv_col;
            m2_z_reg      <= dv_z;
        end
    end

    // Clear sweep control.
    logic              clear_pend_reg;
    logic              sweep_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;
    logic              busy_all;
    logic              sweep_last;

    assign busy_all   = st_busy || ed_busy || dv_busy || m2_valid_reg;
    assign sweep_last = (sweep_cnt_reg == ADDR_W'(PIXELS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_pend_reg <= 1'b1;
            sweep_reg      <= 1'b0;
            sweep_cnt_reg  <= '0;
        end else if (sweep_reg) begin
            sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            if (sweep_last) begin
                sweep_reg <= 1'b0;
            end
        end else if (clear_pend_reg) begin
            // Pixels already in flight must finish their writes first.
            if (!busy_all) begin
                clear_pend_reg <= 1'b0;
                sweep_reg      <= 1'b1;
                sweep_cnt_reg  <= '0;
            end
        end else if (s_beat && (s_tuser == zbr_pkg::OP_CLEAR)) begin
            clear_pend_reg <= 1'b1;
        end
    end

    assign s_tready = adv && !clear_pend_reg && !sweep_reg;

    // Depth memory with a bypass for the write made in the same cycle as the
    // read of the pixel now in the test stage.
    logic [DEPTH_BITS-1:0] rd_z;
    logic [DEPTH_BITS-1:0] old_z;
    logic                  wr_pix;
    logic                  byp_valid_reg;
    logic [ADDR_W-1:0]     byp_addr_reg;
    logic [DEPTH_BITS-1:0] byp_z_reg;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DEPTH_BITS-1:0] ram_wdata;

    assign old_z  = (byp_valid_reg && (byp_addr_reg == m2_addr_reg)) ? byp_z_reg : rd_z;
    assign wr_pix = m2_valid_reg && m2_inside_reg && (m2_z_reg > old_z);

    assign ram_we    = sweep_reg || (adv && wr_pix);
    assign ram_waddr = sweep_reg ? sweep_cnt_reg : m2_addr_reg;
    assign ram_wdata = sweep_reg ? '0 : m2_z_reg;

    zbr_ram #(
        .WIDTH(DEPTH_BITS),
        .DEPTH(PIXELS)
    ) u_depth_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (adv),
        .raddr(dv_addr),
        .rdata(rd_z)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else if (sweep_reg) begin
            byp_valid_reg <= 1'b0;
        end else if (adv) begin
            byp_valid_reg <= wr_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            byp_addr_reg <= m2_addr_reg;
            byp_z_reg    <= m2_z_reg;
        end
    end

    // Output register.
    logic        m_valid_reg;
    logic [8:0]  m_x_reg;
    logic [7:0]  m_y_reg;
    logic [31:0] m_word_reg;
    logic        m_written_reg;
    logic        m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_x_reg       <= 9'(m2_x_reg);
            m_y_reg       <= 8'(m2_y_reg);
            m_word_reg    <= wr_pix ? {zbr_pkg::ALPHA, m2_col_reg} : '0;
            m_written_reg <= wr_pix;
            m_last_reg    <= m2_done_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0000000, m_word_reg, m_y_reg, m_x_reg};
    assign m_tuser  = m_written_reg;
    assign m_tlast  = m_last_reg;

    // The sweep only starts once no pixel can still write the store.
    a_sweep_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(sweep_reg) |-> $past(!busy_all))
        else $error("clear sweep started with pixels in flight");

    // No input beat is taken while the store is being cleared.
    a_no_beat_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (sweep_reg || clear_pend_reg) |-> !s_beat)
        else $error("input beat accepted during depth clear");

    // The sweep address advances by one every cycle.
    a_sweep_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (sweep_reg && $past(sweep_reg)) |->
            (sweep_cnt_reg == ADDR_W'($past(sweep_cnt_reg) + 1'b1)))
        else $error("clear sweep skipped an address");

endmodule

/* dv/zbuffer_triangle_rasterizer_tb.sv */
module zbuffer_triangle_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = zbr_pkg::DEF_SCREEN_WIDTH;
    localparam int SH = zbr_pkg::DEF_SCREEN_HEIGHT;
    localparam logic [zbr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 400000;
    localparam int HOLD_AT = 300;
    localparam int HOLD_LEN = 500;

    typedef struct {
        logic [zbr_pkg::OP_W-1:0] op;
        logic [15:0] crd [6];
        logic [15:0] dep [3];
        logic [23:0] colour;
        bit drain_first;
        bit quiet;
    } beat_t;

    typedef struct {
        logic [8:0] x;
        logic [7:0] y;
        logic [31:0] word;
        logic written;
        logic last;
    } pixel_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [167:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [55:0] m_tdata;
    logic [0:0] m_tuser;
    logic m_tlast;

    zbuffer_triangle_rasterizer dut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // Predictor state.
    logic [15:0] zbuf [SW*SH];
    longint tri_x [3], tri_y [3];
    logic [15:0] tri_z [3];
    logic [23:0] tri_colour;
    longint tri_area;
    int col, row;
    bit loaded;

    beat_t stim_q [$];
    pixel_t pixel_q [$];
    beat_t cur;
    int failures = 0, sent = 0, pixels_seen = 0, writes_seen = 0, loads = 0, clears = 0;
    int gap = 0, idle_rx = 0, hold_left = 0, stall_cycles = 0;
    bit held = 0, quiet = 0, stim_done = 0;

    task automatic swap_vtx(int i, int j);
        longint tx, ty;
        logic [15:0] tz;
        tx = tri_x[i]; ty = tri_y[i]; tz = tri_z[i];
        tri_x[i] = tri_x[j]; tri_y[i] = tri_y[j]; tri_z[i] = tri_z[j];
        tri_x[j] = tx; tri_y[j] = ty; tri_z[j] = tz;
    endtask

    function automatic longint area2();
        return (tri_x[1] - tri_x[0]) * (tri_y[2] - tri_y[0])
             - (tri_y[1] - tri_y[0]) * (tri_x[2] - tri_x[0]);
    endfunction

    task automatic rasterize(beat_t b);
        pixel_t p;
        longint dx, dy, n0, n1, n2;
        longint unsigned sum, z;
        case (b.op)
            zbr_pkg::OP_CLEAR: begin
                foreach (zbuf[i]) zbuf[i] = '0;
                clears++;
            end
            zbr_pkg::OP_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    tri_x[i] = longint'($signed(b.crd[2*i]));
                    tri_y[i] = longint'($signed(b.crd[2*i+1]));
                    tri_z[i] = b.dep[i];
                end
                tri_colour = b.colour;
                if (tri_y[0] > tri_y[1]) swap_vtx(0, 1);
                if (tri_y[0] > tri_y[2]) swap_vtx(0, 2);
                if (tri_y[1] > tri_y[2]) swap_vtx(1, 2);
                if (area2() < 0) swap_vtx(0, 2);
                tri_area = area2();
                col = 0; row = 0; loaded = 1;
                loads++;
            end
            zbr_pkg::OP_PIXEL: if (loaded) begin
                dx = longint'(col) * 16 - tri_x[0];
                dy = longint'(row) * 16 - tri_y[0];
                n1 = dx * (tri_y[2] - tri_y[0]) - dy * (tri_x[2] - tri_x[0]);
                n2 = (tri_x[1] - tri_x[0]) * dy - (tri_y[1] - tri_y[0]) * dx;
                n0 = tri_area - n1 - n2;
                p.x = col[8:0];
                p.y = row[7:0];
                p.written = 0;
                if (tri_area > 0 && n1 >= 0 && n2 >= 0 && n0 >= 0) begin
                    sum = longint'(n1) * tri_z[1] + longint'(n2) * tri_z[2]
                        + longint'(n0) * tri_z[0];
                    z = sum / longint'(tri_area);
                    if (z[15:0] > zbuf[row*SW + col]) begin
                        zbuf[row*SW + col] = z[15:0];
                        p.written = 1;
                    end
                end
                p.word = p.written ? {zbr_pkg::ALPHA, tri_colour} : '0;
                p.last = (col == SW-1) && (row == SH-1);
                if (p.last) begin
                    loaded = 0;
                end else if (col == SW-1) begin
                    col = 0; row++;
                end else begin
                    col++;
                end
                pixel_q.insert(pixel_q.size(), p);
            end
            default: ;
        endcase
    endtask

    // Driver: picks the next beat when the bus is free, with random idle bursts.
    always @(posedge aclk) begin
        logic nvalid;
        beat_t nb;
        nvalid = s_tvalid;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                rasterize(cur);
                sent++;
                nvalid = 0;
            end
            if (!nvalid) begin
                if (gap > 0) begin
                    gap--;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    gap = $urandom_range(1, 14);
                end else if (stim_q.size() > 0
                             && (!stim_q[0].drain_first || pixel_q.size() == 0)) begin
                    nb = stim_q.pop_front();
                    if (nb.quiet) quiet = 1;
                    cur = nb;
                    nvalid = 1;
                    s_tuser <= nb.op;
                    s_tdata <= {nb.colour, nb.dep[2], nb.dep[1], nb.dep[0],
                                nb.crd[5], nb.crd[4], nb.crd[3], nb.crd[2],
                                nb.crd[1], nb.crd[0]};
                end
            end
            s_tvalid <= nvalid;
        end
    end

    // Monitor and checker; also shapes m_tready.
    always @(posedge aclk) begin
        pixel_t e;
        logic nready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                pixels_seen++;
                if (m_tuser[0]) writes_seen++;
                if (pixel_q.size() == 0) begin
                    $error("result beat with no pixel outstanding");
                    failures++;
                end else begin
                    e = pixel_q.pop_front();
                    if (m_tdata[8:0] !== e.x) begin
                        $error("pixel_x: expected %0d, got %0d", e.x, m_tdata[8:0]);
                        failures++;
                    end
                    if (m_tdata[16:9] !== e.y) begin
                        $error("pixel_y: expected %0d, got %0d", e.y, m_tdata[16:9]);
                        failures++;
                    end
                    if (m_tdata[48:17] !== e.word) begin
                        $error("pixel_word: expected %h, got %h", e.word, m_tdata[48:17]);
                        failures++;
                    end
                    if (m_tuser[0] !== e.written) begin
                        $error("pixel_written: expected %0d, got %0d", e.written, m_tuser[0]);
                        failures++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("scan_done: expected %0d, got %0d", e.last, m_tlast);
                        failures++;
                    end
                end
            end
            // One long hold-off so the pipeline backs up into s_tready.
            if (!held && pixels_seen >= HOLD_AT) begin
                held = 1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                nready = 0;
            end else if (quiet) begin
                nready = 1;
            end else if (idle_rx > 0) begin
                idle_rx--;
                nready = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                idle_rx = $urandom_range(1, 14);
                nready = 0;
            end else begin
                nready = 1;
            end
            m_tready <= nready;
        end
    end

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else if (++stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic beat_t make_beat(logic [zbr_pkg::OP_W-1:0] op);
        beat_t b;
        b.op = op;
        foreach (b.crd[i]) b.crd[i] = 16'($urandom());
        foreach (b.dep[i]) b.dep[i] = 16'($urandom());
        b.colour = 24'($urandom());
        b.drain_first = 0;
        b.quiet = 0;
        return b;
    endfunction

    function automatic beat_t make_tri(int x0, int y0, int x1, int y1, int x2, int y2);
        beat_t b;
        b = make_beat(zbr_pkg::OP_LOAD);
        b.crd[0] = 16'(x0); b.crd[1] = 16'(y0);
        b.crd[2] = 16'(x1); b.crd[3] = 16'(y1);
        b.crd[4] = 16'(x2); b.crd[5] = 16'(y2);
        return b;
    endfunction

    task automatic enqueue(beat_t b);
        stim_q.insert(stim_q.size(), b);
    endtask

    task automatic push_steps(int n);
        repeat (n) enqueue(make_beat(zbr_pkg::OP_PIXEL));
    endtask

    initial begin
        beat_t b;
        int rnd_clears = 0;
        foreach (zbuf[i]) zbuf[i] = '0;
        loaded = 0; col = 0; row = 0; tri_area = 0;

        // Directed: steps with no triangle, unused opcode, winding, ties, extremes.
        push_steps(1);
        enqueue(make_beat(OP_UNUSED));
        b = make_tri(0, -16, 80, 32, 0, 32);
        b.dep = '{16'hFFFF, 16'h0000, 16'h8000};
        enqueue(b);
        push_steps(5);
        b = make_tri(-16, -16, 120, -16, 0, 48);
        b.dep = '{16'h0000, 16'hFFFF, 16'hFFFF};
        b.colour = 24'hFFFFFF;
        enqueue(b);
        push_steps(4);
        enqueue(make_tri(0, 0, 16, 16, 32, 32));
        push_steps(2);
        enqueue(make_tri(-32768, -32768, 32767, -32768, -32768, 32767));
        push_steps(3);
        b = make_beat(zbr_pkg::OP_CLEAR);
        enqueue(b);
        push_steps(3);

        // Random: mostly well-formed triangles over the first rows, some noise.
        b = make_tri(-48, -40, 900, 8, 16, 60);
        b.drain_first = 1;
        enqueue(b);
        push_steps(40);
        while (stim_q.size() < 1150) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    enqueue(make_beat(zbr_pkg::OP_LOAD));
                    push_steps($urandom_range(1, 8));
                end
                2: enqueue(make_beat(OP_UNUSED));
                3: begin
                    if (rnd_clears < 2) begin
                        enqueue(make_beat(zbr_pkg::OP_CLEAR));
                        rnd_clears++;
                    end
                end
                default: begin
                    enqueue(make_tri($urandom_range(0, 1200) - 100,
                                     $urandom_range(0, 160) - 80,
                                     $urandom_range(0, 1200) - 100,
                                     $urandom_range(0, 160) - 80,
                                     $urandom_range(0, 1200) - 100,
                                     $urandom_range(0, 160) - 80));
                    push_steps($urandom_range(5, 60));
                end
            endcase
        end

        // Last part at full rate: one large triangle over the first row.
        b = make_tri(0, 0, 10240, 0, 0, 7680);
        b.drain_first = 1;
        b.quiet = 1;
        enqueue(b);
        push_steps(150);

        repeat (6) @(posedge aclk);
        aresetn <= 1;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (!(stim_q.size() == 0 && !s_tvalid && pixel_q.size() == 0)) begin
            @(posedge aclk);
        end
        repeat (60) @(posedge aclk);
        $display("Sent %0d beats: %0d loads, %0d clears, %0d pixel results checked,",
                 sent, loads, clears, pixels_seen);
        $display("%0d of them depth-test writes, with stalls, drains and a full-rate tail.",
                 writes_seen);
        if (failures == 0 && pixel_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
